/* src/pcc_pkg.sv */
// Shared types and constants for the polygon concavity check.
package pcc_pkg;

  localparam int POS_BITS = 16;

  localparam int STEP_BITS = 4;
  localparam logic [STEP_BITS-1:0] STEP_CROSS_END = 4'd6;
  localparam logic [STEP_BITS-1:0] STEP_DOT_END   = 4'd12;
  localparam logic [STEP_BITS-1:0] STEP_DOT_FIRST = 4'd6;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  // Edge components fed to the multiplier for the six cross product terms.
  localparam logic [1:0] CROSS_A [6] = '{AXIS_Y, AXIS_Z, AXIS_Z, AXIS_X, AXIS_X, AXIS_Y};
  localparam logic [1:0] CROSS_B [6] = '{AXIS_Z, AXIS_Y, AXIS_X, AXIS_Z, AXIS_Y, AXIS_X};

  typedef struct packed {
    logic start;
    logic clear;
  } pcc_corner_cmd_t;

  typedef struct packed {
    logic done;
    logic neg;
  } pcc_corner_stat_t;

endpackage

/* src/pcc_mul.sv */
// Shared signed multiplier with a registered product.
module pcc_mul #(
  parameter int A_BITS = 35,
  parameter int B_BITS = 18
) (
  input  logic                             clk,
  input  logic signed [A_BITS-1:0]         op_a,
  input  logic signed [B_BITS-1:0]         op_b,
  output logic signed [A_BITS+B_BITS-1:0]  prod
);

  always_ff @(posedge clk) begin
    prod <= op_a * op_b;
  end

endmodule

/* src/pcc_corner.sv */
// Corner unit: cross product normal and dot product sign on one shared multiplier.
module pcc_corner import pcc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                             clk,
  input  logic                             rst,
  input  pcc_corner_cmd_t                  cmd,
  input  logic [2:0][COORD_BITS-1:0]       va,
  input  logic [2:0][COORD_BITS-1:0]       vb,
  input  logic [2:0][COORD_BITS-1:0]       vc,
  output pcc_corner_stat_t                 stat
);

  localparam int EW = COORD_BITS + 1;
  localparam int TW = 2 * COORD_BITS + 2;
  localparam int NW = 2 * COORD_BITS + 3;
  localparam int WB = COORD_BITS + 2;
  localparam int WP = NW + WB;
  localparam int WD = 4 * COORD_BITS + 8;
  localparam int LO = COORD_BITS + 1;

  logic signed [EW-1:0]    e1 [3];
  logic signed [EW-1:0]    e2 [3];
  logic signed [TW-1:0]    t;
  logic signed [NW-1:0]    n [3];
  logic signed [NW-1:0]    refn [3];
  logic signed [WD-1:0]    d;
  logic [STEP_BITS-1:0]    step;
  logic                    busy;
  logic                    use_dot;
  logic                    have_ref;
  logic                    done;
  logic                    neg;
  logic                    finish;

  logic signed [NW-1:0]    op_a;
  logic signed [WB-1:0]    op_b;
  logic signed [WP-1:0]    prod;
  logic [1:0]              dsel;
  logic signed [NW-1:0]    ncomp;
  logic signed [TW-1:0]    prod_lo;
  logic signed [NW-1:0]    nnew;
  logic signed [WD-1:0]    pext;
  logic signed [WD-1:0]    d_next;

  pcc_mul #(
    .A_BITS(NW),
    .B_BITS(WB)
  ) u_mul (
    .clk  (clk),
    .op_a (op_a),
    .op_b (op_b),
    .prod (prod)
  );

  always_comb begin
    op_a  = '0;
    op_b  = '0;
    dsel  = 2'((step - STEP_DOT_FIRST) >> 1);
    ncomp = n[AXIS_X];
    if (step < STEP_DOT_FIRST) begin
      op_a = NW'(e1[CROSS_A[step[2:0]]]);
      op_b = WB'(e2[CROSS_B[step[2:0]]]);
    end else if (step < STEP_DOT_END) begin
      ncomp = n[dsel];
      op_a  = refn[dsel];
      if (!step[0]) begin
        op_b = WB'(ncomp >>> LO);
      end else begin
        op_b = {1'b0, ncomp[LO-1:0]};
      end
    end
  end

  assign prod_lo = prod[TW-1:0];
  assign nnew    = NW'(t) - NW'(prod_lo);
  assign pext    = WD'(prod);
  assign d_next  = d + (step[0] ? (pext <<< LO) : pext);
  assign finish  = busy && !cmd.start
                 && (use_dot ? (step == STEP_DOT_END) : (step == STEP_CROSS_END));

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      have_ref <= 1'b0;
      step     <= '0;
    end else begin
      done <= finish;
      if (cmd.clear) begin
        have_ref <= 1'b0;
      end else if (finish && !use_dot) begin
        have_ref <= 1'b1;
      end
      if (cmd.start) begin
        busy    <= 1'b1;
        step    <= '0;
        use_dot <= have_ref;
        d       <= '0;
        for (int i = 0; i < 3; i++) begin
          e1[i] <= EW'($signed(vb[i])) - EW'($signed(va[i]));
          e2[i] <= EW'($signed(vc[i])) - EW'($signed(vb[i]));
        end
      end else if (busy) begin
        step <= step + 1'b1;
        case (step)
          4'd1, 4'd3, 4'd5: t <= prod_lo;
          4'd2: n[AXIS_X] <= nnew;
          4'd4: n[AXIS_Y] <= nnew;
          4'd6: n[AXIS_Z] <= nnew;
          default: begin
            if (step inside {[4'd7:4'd12]}) begin
              d <= d_next;
            end
          end
        endcase
        if (finish) begin
          busy <= 1'b0;
          neg  <= use_dot ? d_next[WD-1] : 1'b0;
        end
        if (finish && !use_dot) begin
          refn[AXIS_X] <= n[AXIS_X];
          refn[AXIS_Y] <= n[AXIS_Y];
          refn[AXIS_Z] <= nnew;
        end
      end
    end
  end

  assign stat.done = done;
  assign stat.neg  = neg;

endmodule

/* src/polygon_concavity_check.sv */
// Top level of the polygon concavity check: vertex store, polygon sequencer, result register.
//
// Vertices enter one item at a time on the input channel (in_valid, in_stall) as
// pos_x, pos_y, pos_z with last_vertex set on the final vertex of a polygon. The
// block takes one vertex, then holds in_stall high while it works on it. From the
// third vertex on, a vertex runs one corner through the corner unit: the first corner
// computes the normal only (six products), every other corner the normal plus a dot
// product split into six more products. A final vertex of four or more runs its own
// corner and the two wrap-around corners, and its result item then appears on the
// output channel (out_valid, out_stall). All products go through one multiplier.
// The result sits in an output register: while the receiver stalls it holds, and
// the next polygon's vertices are still taken; only the next final vertex waits
// for the register to empty. Polygons of fewer than four vertices report zero.
// Reset (rst, synchronous) empties the output register and starts a new polygon.
module polygon_concavity_check import pcc_pkg::*; #(
  parameter int COORD_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [POS_BITS-1:0]  pos_x,
  input  logic signed [POS_BITS-1:0]  pos_y,
  input  logic signed [POS_BITS-1:0]  pos_z,
  input  logic                        last_vertex,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        concave
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECIDE = 3'd1;
  localparam logic [2:0] S_RUN    = 3'd2;
  localparam logic [2:0] S_WRAP   = 3'd3;
  localparam logic [2:0] S_FIN    = 3'd4;

  localparam logic [1:0] CORNER_MID    = 2'd0;
  localparam logic [1:0] CORNER_WRAP_A = 2'd1;
  localparam logic [1:0] CORNER_WRAP_B = 2'd2;

  localparam logic [2:0] VCOUNT_MAX = 3'd4;

  logic [2:0]                  state;
  logic [1:0]                  csel;
  logic [1:0]                  start_sel;
  logic [2:0]                  vcount;
  logic                        concave_seen;
  logic                        last;
  logic [2:0][COORD_BITS-1:0]  pos_in;
  logic [2:0][COORD_BITS-1:0]  cur;
  logic [2:0][COORD_BITS-1:0]  first0;
  logic [2:0][COORD_BITS-1:0]  first1;
  logic [2:0][COORD_BITS-1:0]  rec0;
  logic [2:0][COORD_BITS-1:0]  rec1;
  logic [2:0][COORD_BITS-1:0]  ca;
  logic [2:0][COORD_BITS-1:0]  cb;
  logic [2:0][COORD_BITS-1:0]  cc;
  logic                        out_free;
  pcc_corner_cmd_t             ccmd;
  pcc_corner_stat_t            cstat;

  if (COORD_BITS <= POS_BITS) begin : g_narrow
    assign pos_in[AXIS_X] = pos_x[COORD_BITS-1:0];
    assign pos_in[AXIS_Y] = pos_y[COORD_BITS-1:0];
    assign pos_in[AXIS_Z] = pos_z[COORD_BITS-1:0];
  end else begin : g_wide
    assign pos_in[AXIS_X] = {{(COORD_BITS-POS_BITS){1'b0}}, pos_x};
    assign pos_in[AXIS_Y] = {{(COORD_BITS-POS_BITS){1'b0}}, pos_y};
    assign pos_in[AXIS_Z] = {{(COORD_BITS-POS_BITS){1'b0}}, pos_z};
  end

  assign in_stall = (state != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    case (state)
      S_DECIDE: start_sel = CORNER_MID;
      S_WRAP:   start_sel = CORNER_WRAP_A;
      default:  start_sel = CORNER_WRAP_B;
    endcase
    ccmd.start = (state == S_DECIDE && vcount >= 3'd2)
              || (state == S_WRAP && last && vcount >= 3'd3)
              || (state == S_RUN && cstat.done && csel == CORNER_WRAP_A);
    ccmd.clear = (state == S_FIN) && out_free;
    case (start_sel)
      CORNER_MID: begin
        ca = rec0;
        cb = rec1;
        cc = cur;
      end
      CORNER_WRAP_A: begin
        ca = rec1;
        cb = cur;
        cc = first0;
      end
      default: begin
        ca = cur;
        cb = first0;
        cc = first1;
      end
    endcase
  end

  pcc_corner #(
    .COORD_BITS(COORD_BITS)
  ) u_corner (
    .clk  (clk),
    .rst  (rst),
    .cmd  (ccmd),
    .va   (ca),
    .vb   (cb),
    .vc   (cc),
    .stat (cstat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      csel         <= CORNER_MID;
      vcount       <= '0;
      concave_seen <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (state == S_FIN && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (ccmd.start) begin
        csel <= start_sel;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cur   <= pos_in;
            last  <= last_vertex;
            state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (vcount < 3'd2) begin
            if (vcount[0]) begin
              first1 <= cur;
            end else begin
              first0 <= cur;
            end
            state <= S_WRAP;
          end else begin
            state <= S_RUN;
          end
        end
        S_RUN: begin
          if (cstat.done) begin
            if (cstat.neg) begin
              concave_seen <= 1'b1;
            end
            if (csel == CORNER_MID) begin
              state <= S_WRAP;
            end else if (csel == CORNER_WRAP_B) begin
              state <= S_FIN;
            end
          end
        end
        S_WRAP: begin
          if (!last) begin
            rec0 <= rec1;
            rec1 <= cur;
            if (vcount < VCOUNT_MAX) begin
              vcount <= vcount + 3'd1;
            end
            state <= S_IDLE;
          end else if (vcount >= 3'd3) begin
            state <= S_RUN;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            concave      <= concave_seen;
            vcount       <= '0;
            concave_seen <= 1'b0;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_done_in_run: assert property (@(posedge clk) disable iff (rst)
    cstat.done |-> state == S_RUN)
    else $error("corner unit finished outside of a corner run");

  a_result_from_fin: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_FIN)
    else $error("result item raised outside of the finish step");

  a_result_restarts: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> vcount == 3'd0 && !concave_seen && state == S_IDLE)
    else $error("polygon state not cleared after the result");

  a_concave_needs_corners: assert property (@(posedge clk) disable iff (rst)
    concave_seen |-> vcount >= 3'd2)
    else $error("concavity flagged before any corner was tested");

endmodule

/* sim/polygon_concavity_check_tb.sv */
// Self-checking testbench for the polygon concavity check: predicted concave flags vs. results.
`timescale 1ns / 1ps
module polygon_concavity_check_tb import pcc_pkg::*; ();

  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_CYCLES = 80;
  localparam int HOLD_CYCLES = 600;
  localparam int MAX_REPORTS = 10;
  localparam logic [10:0] RECEIVER_PATTERN = 11'b11100110100;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_t;

  typedef struct {
    longint x;
    longint y;
    longint z;
  } vec_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [POS_BITS-1:0] pos_x = '0;
  logic signed [POS_BITS-1:0] pos_y = '0;
  logic signed [POS_BITS-1:0] pos_z = '0;
  logic last_vertex = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic concave;

  polygon_concavity_check #(
    .COORD_BITS(16)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .pos_x(pos_x),
    .pos_y(pos_y),
    .pos_z(pos_z),
    .last_vertex(last_vertex),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .concave(concave)
  );

  vec_t first_pair [2];
  vec_t recent_pair [2];
  vec_t ref_normal;
  bit ref_valid;
  int seen_count;
  bit concave_found;
  bit expected_concave [$];

  int fail_count = 0;
  int vertices_sent = 0;
  int burst_left = 0;
  int gap_max = 0;
  stall_mode_t stall_mode = STALL_NONE;
  int hold_requests = 0;
  int hold_served = 0;
  int hold_left = 0;
  int stall_phase = 0;
  int cycle_count = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic vec_t vtx(input longint x, input longint y, input longint z);
    vec_t v;
    v.x = x;
    v.y = y;
    v.z = z;
    return v;
  endfunction

  function automatic vec_t corner_normal(input vec_t a, input vec_t b, input vec_t c);
    vec_t e1, e2, n;
    e1.x = b.x - a.x;
    e1.y = b.y - a.y;
    e1.z = b.z - a.z;
    e2.x = c.x - b.x;
    e2.y = c.y - b.y;
    e2.z = c.z - b.z;
    n.x = e1.y * e2.z - e1.z * e2.y;
    n.y = e1.z * e2.x - e1.x * e2.z;
    n.z = e1.x * e2.y - e1.y * e2.x;
    return n;
  endfunction

  function automatic void clear_polygon();
    first_pair[0] = vtx(0, 0, 0);
    first_pair[1] = vtx(0, 0, 0);
    recent_pair[0] = vtx(0, 0, 0);
    recent_pair[1] = vtx(0, 0, 0);
    ref_normal = vtx(0, 0, 0);
    ref_valid = 1'b0;
    seen_count = 0;
    concave_found = 1'b0;
  endfunction

  // The first corner sets the reference; later corners flag on a negative dot product.
  function automatic void score_corner(input vec_t a, input vec_t b, input vec_t c);
    vec_t n;
    logic signed [71:0] rx, ry, rz, nx, ny, nz, dot;
    n = corner_normal(a, b, c);
    if (!ref_valid) begin
      ref_normal = n;
      ref_valid = 1'b1;
      return;
    end
    rx = ref_normal.x;
    ry = ref_normal.y;
    rz = ref_normal.z;
    nx = n.x;
    ny = n.y;
    nz = n.z;
    dot = rx * nx + ry * ny + rz * nz;
    if (dot < 0) concave_found = 1'b1;
  endfunction

  function automatic void model_vertex(input logic signed [POS_BITS-1:0] x,
                                       input logic signed [POS_BITS-1:0] y,
                                       input logic signed [POS_BITS-1:0] z,
                                       input logic is_last);
    vec_t cur;
    cur.x = x;
    cur.y = y;
    cur.z = z;
    if (seen_count < 2) begin
      first_pair[seen_count] = cur;
    end else begin
      score_corner(recent_pair[0], recent_pair[1], cur);
    end
    if (!is_last) begin
      recent_pair[0] = recent_pair[1];
      recent_pair[1] = cur;
      if (seen_count < 4) seen_count++;
    end else begin
      if (seen_count + 1 >= 4) begin
        score_corner(recent_pair[1], cur, first_pair[0]);
        score_corner(cur, first_pair[0], first_pair[1]);
        expected_concave = {expected_concave, concave_found};
      end else begin
        expected_concave = {expected_concave, 1'b0};
      end
      clear_polygon();
    end
  endfunction

  function automatic void report_failure(input string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) $display("%0t: %s", $realtime, msg);
  endfunction

  task automatic send_vertex(input logic signed [POS_BITS-1:0] x,
                             input logic signed [POS_BITS-1:0] y,
                             input logic signed [POS_BITS-1:0] z,
                             input logic is_last);
    int gap;
    in_valid <= 1'b1;
    pos_x <= x;
    pos_y <= y;
    pos_z <= z;
    last_vertex <= is_last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    model_vertex(x, y, z, is_last);
    vertices_sent++;
    if (gap_max > 0) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 12);
        gap = $urandom_range(1, gap_max);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic send_polygon(input vec_t verts [$]);
    for (int i = 0; i < verts.size(); i++) begin
      send_vertex(16'(verts[i].x), 16'(verts[i].y), 16'(verts[i].z), i == verts.size() - 1);
    end
  endtask

  // Planar polygon around a circle; dented vertices pull inward and usually make it concave.
  task automatic send_ring(input int count, input int radius, input int dent_pct);
    vec_t verts [$];
    vec_t p;
    real ang, rad;
    int u, v, w, h, ta, tb, plane;
    bit reverse;
    plane = $urandom_range(0, 2);
    w = $urandom_range(0, 16000) - 8000;
    ta = $urandom_range(0, 2) - 1;
    tb = $urandom_range(0, 2) - 1;
    reverse = $urandom_range(0, 1);
    for (int i = 0; i < count; i++) begin
      ang = 6.283185307 * (i + $urandom_range(0, 40) / 100.0) / count;
      rad = radius;
      if ($urandom_range(0, 99) < dent_pct) rad = radius / 4.0;
      u = $rtoi(rad * $cos(ang));
      v = $rtoi(rad * $sin(ang));
      if (reverse) v = -v;
      h = w + ta * u + tb * v;
      case (plane)
        0: p = vtx(u, v, h);
        1: p = vtx(h, u, v);
        default: p = vtx(v, h, u);
      endcase
      verts = {verts, p};
    end
    send_polygon(verts);
  endtask

  // Unstructured vertices; a span of zero uses the whole coordinate range.
  task automatic send_noise(input int count, input int span);
    vec_t verts [$];
    for (int i = 0; i < count; i++) begin
      if (span == 0) begin
        verts = {verts, vtx(longint'($signed(16'($urandom))), longint'($signed(16'($urandom))),
                            longint'($signed(16'($urandom))))};
      end else begin
        verts = {verts, vtx($urandom_range(0, 2 * span) - span,
                            $urandom_range(0, 2 * span) - span,
                            $urandom_range(0, 2 * span) - span)};
      end
    end
    send_polygon(verts);
  endtask

  task automatic test_short_polygons();
    send_polygon('{vtx(32767, -32768, -1)});
    send_polygon('{vtx(-32768, 32767, 0), vtx(0, -1, 32767)});
    send_polygon('{vtx(0, 0, 0), vtx(256, 0, 0), vtx(0, 256, 0)});
  endtask

  task automatic test_extreme_coords();
    send_polygon('{vtx(-32768, -32768, 0), vtx(32767, -32768, -32768),
                   vtx(32767, 32767, 32767), vtx(-32768, 32767, -1)});
  endtask

  task automatic test_convex_and_concave();
    send_polygon('{vtx(0, 0, 0), vtx(256, 0, 0), vtx(256, 256, 0), vtx(0, 256, 0)});
    send_polygon('{vtx(0, 0, 0), vtx(512, 0, 0), vtx(128, 128, 0), vtx(0, 512, 0)});
  endtask

  // Collinear opening vertices leave a zero reference, so nothing can flag.
  task automatic test_degenerate_corners();
    send_polygon('{vtx(0, 0, 0), vtx(256, 0, 0), vtx(512, 0, 0),
                   vtx(512, 512, 0), vtx(128, 64, 0)});
  endtask

  task automatic test_random_polygons(input int count, input int gaps, input stall_mode_t mode);
    int target;
    int pick;
    gap_max = gaps;
    stall_mode = mode;
    target = vertices_sent + count;
    while (vertices_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        send_ring($urandom_range(0, 9) == 0 ? 3 : $urandom_range(4, 10),
                  $urandom_range(1, 12000), $urandom_range(0, 1) ? 30 : 0);
      end else if (pick < 85) begin
        send_noise($urandom_range(1, 8), 3);
      end else begin
        send_noise($urandom_range(1, 8), 0);
      end
    end
  endtask

  // The receiver holds off while whole polygons keep arriving, so the input backs up.
  task automatic test_output_hold_off();
    gap_max = 0;
    stall_mode = STALL_NONE;
    hold_requests++;
    repeat (6) send_ring(4, 10000, 30);
  endtask

  always @(posedge clk) begin
    stall_phase <= (stall_phase == 10) ? 0 : stall_phase + 1;
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else if (hold_served != hold_requests) begin
      hold_served <= hold_requests;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      case (stall_mode)
        STALL_RANDOM: out_stall <= ($urandom_range(0, 99) < 35);
        STALL_PATTERN: out_stall <= RECEIVER_PATTERN[stall_phase];
        default: out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin
    bit want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_concave.size() == 0) begin
        report_failure($sformatf("unexpected item, concave=%b", concave));
      end else begin
        want = expected_concave.pop_front();
        if (concave !== want) begin
          report_failure($sformatf("concave mismatch: expected %b, actual %b", want, concave));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("polygon_concavity_check test failed");
      $finish;
    end
  end

  initial begin
    clear_polygon();
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_short_polygons();
    test_extreme_coords();
    test_convex_and_concave();
    test_degenerate_corners();
    test_random_polygons(150, 0, STALL_NONE);
    test_random_polygons(250, 20, STALL_RANDOM);
    test_output_hold_off();
    test_random_polygons(250, 6, STALL_PATTERN);
    in_valid <= 1'b0;
    while (expected_concave.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("polygon_concavity_check test passed");
    end else begin
      $display("polygon_concavity_check test failed");
    end
    $finish;
  end

endmodule
